// File: design/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg: shared types and constants of the websocket frame decoder
// parser phases, result codes and the result records passed between parts
// ----------------------------------------------------------------------------
package wfd_pkg;

  // width that a payload length may take before it counts as too long; a set bit 63 always counts as too long
  localparam int unsigned LENGTH_BITS = 64;

  // depth of the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_PAY
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_TERM,
    KIND_EMPTY,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OPCODE,
    ERR_SHORT,
    ERR_LENGTH
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
    logic       is_text;
    logic       fin;
    logic       last;
  } res_t;

  // results caused by one received byte: one or two
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } pair_t;

endpackage

// File: design/wfd_front.sv
// ----------------------------------------------------------------------------
// wfd_front: frame header parser
// tracks the frame phase and turns each received byte into its results
// ----------------------------------------------------------------------------
module wfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     data_byte_i,
  input  logic           chunk_start_i,
  input  logic           chunk_end_i,
  output logic           wr_o,
  output wfd_pkg::pair_t pair_o
);
  import wfd_pkg::*;

  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  phase_e                 phase_q, phase_d, phase_step;
  logic [3:0]             op_q, op_d;
  logic                   fin_q, fin_d;
  logic [63:0]            len_q, len_d;
  logic [3:0]             lbl_q, lbl_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             kidx_q, kidx_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;

  logic [3:0]  op_new;
  logic        op_ok;
  logic [6:0]  short_len;
  logic [3:0]  lbl_dec;
  logic        cnt_done;
  logic [63:0] len_shift;
  logic        too_long;
  logic [31:0] key_shift;
  logic        len_zero;
  logic        pay_last;
  logic        cur_text;
  logic        cur_fin;
  logic        end_err;
  logic [7:0]  key_byte;
  logic        a_vld, b_vld;
  res_t        res_a, res_b;

  function automatic res_t mk_res(logic [7:0] data, kind_e kind, err_e err,
                                  logic is_text, logic fin, logic last);
    res_t r;
    r.data    = data;
    r.kind    = kind;
    r.err     = err;
    r.is_text = is_text;
    r.fin     = fin;
    r.last    = last;
    return r;
  endfunction

  assign op_new    = data_byte_i[3:0];
  assign op_ok     = (op_new == OPC_TEXT) || (op_new == OPC_BINARY);
  assign short_len = data_byte_i[6:0];
  assign lbl_dec   = lbl_q - 4'd1;
  assign cnt_done  = (lbl_dec == 4'd0);
  assign len_shift = {len_q[55:0], data_byte_i};
  assign too_long  = len_shift[63] || ((len_shift >> LENGTH_BITS) != 64'd0);
  assign key_shift = {key_q[23:0], data_byte_i};
  assign len_zero  = (len_q[LENGTH_BITS-1:0] == '0);
  assign pay_last  = (rem_q == LENGTH_BITS'(1));
  assign cur_text  = chunk_start_i ? (op_new == OPC_TEXT) : (op_q == OPC_TEXT);
  assign cur_fin   = chunk_start_i ? data_byte_i[7] : fin_q;

  // next phase
  always_comb begin
    phase_step = phase_q;
    if (chunk_start_i) begin
      phase_step = op_ok ? PH_LEN : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_IDLE: phase_step = PH_IDLE;
        PH_LEN:  phase_step = (short_len <= LEN_MAX_SHORT) ? PH_KEY : PH_EXT;
        PH_EXT:  phase_step = cnt_done ? (too_long ? PH_IDLE : PH_KEY) : PH_EXT;
        PH_KEY:  phase_step = cnt_done ? (len_zero ? PH_IDLE : PH_PAY) : PH_KEY;
        PH_PAY:  phase_step = pay_last ? PH_IDLE : PH_PAY;
        default: phase_step = PH_IDLE;
      endcase
    end
    end_err = acc_i && chunk_end_i && (phase_step != PH_IDLE);
    phase_d = phase_q;
    if (acc_i) begin
      phase_d = chunk_end_i ? PH_IDLE : phase_step;
    end
  end

  // header fields, key and counters
  always_comb begin
    op_d   = op_q;
    fin_d  = fin_q;
    len_d  = len_q;
    lbl_d  = lbl_q;
    key_d  = key_q;
    kidx_d = kidx_q;
    rem_d  = rem_q;
    if (acc_i) begin
      if (chunk_start_i) begin
        fin_d  = data_byte_i[7];
        op_d   = op_new;
        len_d  = '0;
        lbl_d  = '0;
        key_d  = '0;
        kidx_d = '0;
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            if (short_len <= LEN_MAX_SHORT) begin
              len_d = 64'(short_len);
              lbl_d = KEY_BYTES;
            end else begin
              len_d = '0;
              lbl_d = (short_len == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            end
          end
          PH_EXT: begin
            len_d = len_shift;
            lbl_d = (cnt_done && !too_long) ? KEY_BYTES : lbl_dec;
          end
          PH_KEY: begin
            key_d = key_shift;
            lbl_d = lbl_dec;
            if (cnt_done) begin
              kidx_d = '0;
              rem_d  = len_q[LENGTH_BITS-1:0];
            end
          end
          PH_PAY: begin
            kidx_d = kidx_q + 2'd1;
            rem_d  = rem_q - LENGTH_BITS'(1);
          end
          default: begin
            op_d = op_q;
          end
        endcase
      end
    end
  end

  // mask key byte in transmission order
  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // results of this byte
  always_comb begin
    a_vld = 1'b0;
    b_vld = 1'b0;
    res_a = mk_res(8'd0, KIND_ERROR, ERR_NONE, cur_text, cur_fin, 1'b1);
    res_b = res_a;
    if (acc_i) begin
      if (chunk_start_i) begin
        if (!op_ok) begin
          a_vld = 1'b1;
          res_a = mk_res(8'd0, KIND_ERROR, ERR_OPCODE, cur_text, cur_fin, 1'b1);
        end
      end else begin
        unique case (phase_q)
          PH_EXT: begin
            if (cnt_done && too_long) begin
              a_vld = 1'b1;
              res_a = mk_res(8'd0, KIND_ERROR, ERR_LENGTH, cur_text, cur_fin, 1'b1);
            end
          end
          PH_KEY: begin
            if (cnt_done && len_zero) begin
              a_vld = 1'b1;
              res_a = mk_res(8'd0, cur_text ? KIND_TERM : KIND_EMPTY, ERR_NONE,
                             cur_text, cur_fin, 1'b1);
            end
          end
          PH_PAY: begin
            a_vld = 1'b1;
            res_a = mk_res(data_byte_i ^ key_byte, KIND_PAYLOAD, ERR_NONE,
                           cur_text, cur_fin, pay_last && !cur_text);
            if (pay_last && cur_text) begin
              b_vld = 1'b1;
              res_b = mk_res(8'd0, KIND_TERM, ERR_NONE, cur_text, cur_fin, 1'b1);
            end
          end
          default: begin
            a_vld = 1'b0;
          end
        endcase
      end
      // chunk ran out before the frame completed
      if (end_err) begin
        if (a_vld) begin
          b_vld = 1'b1;
          res_b = mk_res(8'd0, KIND_ERROR, ERR_SHORT, cur_text, cur_fin, 1'b1);
        end else begin
          a_vld = 1'b1;
          res_a = mk_res(8'd0, KIND_ERROR, ERR_SHORT, cur_text, cur_fin, 1'b1);
        end
      end
    end
  end

  assign wr_o       = a_vld;
  assign pair_o.r0  = res_a;
  assign pair_o.r1  = res_b;
  assign pair_o.two = b_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= '0;
      fin_q   <= 1'b0;
      len_q   <= '0;
      lbl_q   <= '0;
      key_q   <= '0;
      kidx_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      fin_q   <= fin_d;
      len_q   <= len_d;
      lbl_q   <= lbl_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: design/wfd_queue.sv
// ----------------------------------------------------------------------------
// wfd_queue: short queue of result pairs
// decouples the parser from the output stage
// ----------------------------------------------------------------------------
module wfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  wfd_pkg::pair_t wdata_i,
  input  logic           rd_i,
  output wfd_pkg::pair_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import wfd_pkg::*;

  pair_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_wr, do_rd;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (do_rd) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: design/wfd_back.sv
// ----------------------------------------------------------------------------
// wfd_back: output stage
// unpacks result pairs and presents one result at a time
// ----------------------------------------------------------------------------
module wfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  wfd_pkg::pair_t q_data_i,
  output logic           q_rd_o,
  input  logic           pop_i,
  output logic           empty_o,
  output wfd_pkg::res_t  res_o
);
  import wfd_pkg::*;

  pair_t cur_q;
  logic  vld_q;
  logic  sel_q;
  logic  take;
  logic  pair_done;

  assign take      = pop_i && vld_q;
  assign pair_done = take && (sel_q || !cur_q.two);
  assign q_rd_o    = !q_empty_i && (!vld_q || pair_done);
  assign empty_o   = !vld_q;
  assign res_o     = sel_q ? cur_q.r1 : cur_q.r0;

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      if (q_rd_o) begin
        vld_q <= 1'b1;
        sel_q <= 1'b0;
      end else if (pair_done) begin
        vld_q <= 1'b0;
        sel_q <= 1'b0;
      end else if (take) begin
        sel_q <= 1'b1;
      end
    end
  end

endmodule

// File: design/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder: receive-side websocket frame decoder
// parses frame headers byte by byte and emits unmasked payload bytes
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// input     in         push / full        data_byte_i, chunk_start_i, chunk_end_i
// result    out        empty / pop        out_byte_o, kind_o, error_code_o,
//                                         is_text_o, fin_flag_o, last_o
//
// one received byte is taken per cycle while full is low; the parser decides
// the results of a byte in the cycle it is taken and writes them to a
// four-entry queue of result pairs
// a byte gives zero, one or two results; the output stage delivers one result
// per cycle while pop is high, so bytes that give two results can fill the queue and raise full
// a result is registered in the queue and then in the output stage before it appears on the ports
// reset returns the parser to idle, waiting for a chunk start, and empties the
// queue; no clearing pass is needed
// a stalled result side stalls the input only once the queue is full
//
module websocket_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_start_i,
  input  logic       chunk_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [1:0] error_code_o,
  output logic       is_text_o,
  output logic       fin_flag_o,
  output logic       last_o
);
  import wfd_pkg::*;

  // request accepted by the parser
  logic  acc;
  // parser to queue
  logic  fr_wr;
  pair_t fr_pair;
  // queue to output stage
  pair_t q_data;
  logic  q_full, q_empty, q_rd;
  // result on the ports
  res_t  res;

  assign acc  = push && !q_full;
  assign full = q_full;

  // front: header parser and unmasking
  wfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .data_byte_i   (data_byte_i),
    .chunk_start_i (chunk_start_i),
    .chunk_end_i   (chunk_end_i),
    .wr_o          (fr_wr),
    .pair_o        (fr_pair)
  );

  // queue between parser and output stage
  wfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_wr),
    .wdata_i (fr_pair),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: one result per request on the output side
  wfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign out_byte_o   = res.data;
  assign kind_o       = res.kind;
  assign error_code_o = res.err;
  assign is_text_o    = res.is_text;
  assign fin_flag_o   = res.fin;
  assign last_o       = res.last;

endmodule
